/* rtl/motor_command_speed_ramp_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the motor command and speed-ramp controller
// Concurrent checks on a clock with an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_SPEED_RAMP_ASSERT_SVH
`define MOTOR_COMMAND_SPEED_RAMP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCSR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mcsr_pkg.sv */
// ----------------------------------------------------------------------------
// Motor command and speed-ramp package
// Types, codes, reset values and division constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsr_pkg;

	localparam int SpeedW  = 12;
	localparam int ReqW    = 16;
	localparam int RunW    = 32;
	localparam int CfgIdxW = 3;
	localparam int SecsW   = 7;

	// Reciprocal multipliers: x / 20 = (x * 3277) >> 16 for 12-bit x,
	// x / 1000 = (x * 67109) >> 26 for 16-bit x.
	localparam logic [11:0] Div20Mul    = 12'd3277;
	localparam int          Div20Shift  = 16;
	localparam logic [16:0] Div1000Mul  = 17'd67109;
	localparam int          Div1000Shift = 26;

	localparam logic [SpeedW-1:0] RstMaxSpeed      = 12'd3000;
	localparam logic [SpeedW-1:0] RstRampStep      = 12'd120;
	localparam logic [SpeedW-1:0] RstDefaultStart  = 12'd1500;
	localparam logic [SpeedW-1:0] RstStallThresh   = 12'd500;

	typedef enum logic [2:0] {
		OP_START       = 3'd0,
		OP_STOP        = 3'd1,
		OP_SET_TARGET  = 3'd2,
		OP_ESTOP       = 3'd3,
		OP_CLEAR_ALARM = 3'd4,
		OP_QUERY       = 3'd5,
		OP_TICK        = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		MODE_STOPPED  = 3'd0,
		MODE_STARTING = 3'd1,
		MODE_RUNNING  = 3'd2,
		MODE_STOPPING = 3'd3,
		MODE_ESTOP    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_REJECTED = 2'd1,
		STATUS_RANGE    = 2'd2
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MAX_SPEED     = 3'd0,
		CFG_RAMP_STEP     = 3'd1,
		CFG_DEFAULT_START = 3'd2,
		CFG_STALL_THRESH  = 3'd3,
		CFG_STALL_FAULT   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [SpeedW-1:0] max_speed;
		logic [SpeedW-1:0] ramp_step;
		logic [SpeedW-1:0] default_start_speed;
		logic [SpeedW-1:0] stall_threshold;
		logic              stall_fault;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [SpeedW-1:0] speed;
		logic [SpeedW-1:0] goal;
		logic [RunW-1:0]   runtime;
	} state_t;

endpackage

`default_nettype wire

/* rtl/mcsr_cmd_if.sv */
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command or tick item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcsr_cmd_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               operation;
	logic [mcsr_pkg::ReqW-1:0] target_speed;
	logic [mcsr_pkg::ReqW-1:0] elapsed_ms;

	modport source (output valid, output operation, output target_speed,
		output elapsed_ms, input ready);
	modport sink (input valid, input operation, input target_speed,
		input elapsed_ms, output ready);
endinterface

`default_nettype wire

/* rtl/mcsr_rsp_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one status and state report item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcsr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [2:0]                  motor_state;
	logic [mcsr_pkg::SpeedW-1:0] speed_now;
	logic [mcsr_pkg::SpeedW-1:0] speed_goal;
	logic [mcsr_pkg::RunW-1:0]   run_seconds;

	modport source (output valid, output status, output motor_state,
		output speed_now, output speed_goal, output run_seconds, input ready);
	modport sink (input valid, input status, input motor_state,
		input speed_now, input speed_goal, input run_seconds, output ready);
endinterface

`default_nettype wire

/* rtl/mcsr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for limits, default start speed, ramp step and stall injection.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsr_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mcsr_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [mcsr_pkg::SpeedW-1:0]   cfg_wdata,
	output mcsr_pkg::cfg_t                     cfg
);

	mcsr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed           <= mcsr_pkg::RstMaxSpeed;
			cfg_q.ramp_step           <= mcsr_pkg::RstRampStep;
			cfg_q.default_start_speed <= mcsr_pkg::RstDefaultStart;
			cfg_q.stall_threshold     <= mcsr_pkg::RstStallThresh;
			cfg_q.stall_fault         <= 1'b0;
		end else if (cfg_we) begin
			unique case (mcsr_pkg::cfg_idx_t'(cfg_index))
				mcsr_pkg::CFG_MAX_SPEED:     cfg_q.max_speed <= cfg_wdata;
				mcsr_pkg::CFG_RAMP_STEP:     cfg_q.ramp_step <= cfg_wdata;
				mcsr_pkg::CFG_DEFAULT_START: cfg_q.default_start_speed <= cfg_wdata;
				mcsr_pkg::CFG_STALL_THRESH:  cfg_q.stall_threshold <= cfg_wdata;
				mcsr_pkg::CFG_STALL_FAULT:   cfg_q.stall_fault <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/mcsr_step.sv */
// ----------------------------------------------------------------------------
// Command and tick step
// Next-state and status logic for one item: command checks, speed ramp,
// stall clamp and saturating run-time count.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsr_step (
	input  wire mcsr_pkg::cfg_t               cfg,
	input  wire mcsr_pkg::state_t             cur,
	input  wire mcsr_pkg::op_t                op,
	input  wire logic [mcsr_pkg::ReqW-1:0]    target_speed,
	input  wire logic [mcsr_pkg::ReqW-1:0]    elapsed_ms,
	output mcsr_pkg::state_t                  nxt,
	output mcsr_pkg::status_t                 status
);

	logic [mcsr_pkg::SpeedW-1:0] goal_eff;
	logic [mcsr_pkg::SpeedW:0]   up_sum;
	logic [mcsr_pkg::SpeedW:0]   dn_limit;
	logic [mcsr_pkg::SpeedW-1:0] ramp_up;
	logic [mcsr_pkg::SpeedW-1:0] ramp_dn_goal;
	logic [mcsr_pkg::SpeedW-1:0] ramp_dn_zero;
	logic [mcsr_pkg::SpeedW-1:0] ramp_speed;
	logic [mcsr_pkg::SpeedW-1:0] tick_speed;
	mcsr_pkg::mode_t             tick_mode;
	logic [2*mcsr_pkg::SpeedW-1:0] div20_prod;
	logic [mcsr_pkg::ReqW+16:0]  ms_prod;
	logic [mcsr_pkg::SecsW-1:0]  secs;
	logic [mcsr_pkg::RunW:0]     run_sum;
	logic                        active;

	assign goal_eff = (cur.mode == mcsr_pkg::MODE_STARTING && cur.goal == '0)
		? cfg.default_start_speed : cur.goal;
	assign up_sum   = {1'b0, cur.speed} + {1'b0, cfg.ramp_step};
	assign dn_limit = {1'b0, goal_eff} + {1'b0, cfg.ramp_step};
	assign ramp_up  = (up_sum < {1'b0, goal_eff}) ? up_sum[mcsr_pkg::SpeedW-1:0] : goal_eff;
	assign ramp_dn_goal = ({1'b0, cur.speed} > dn_limit)
		? cur.speed - cfg.ramp_step : goal_eff;
	assign ramp_dn_zero = (cur.speed > cfg.ramp_step) ? cur.speed - cfg.ramp_step : '0;

	assign div20_prod = goal_eff * mcsr_pkg::Div20Mul;
	assign ms_prod    = elapsed_ms * mcsr_pkg::Div1000Mul;
	assign secs       = ms_prod[mcsr_pkg::Div1000Shift +: mcsr_pkg::SecsW];
	assign active     = (cur.mode == mcsr_pkg::MODE_STARTING) ||
		(cur.mode == mcsr_pkg::MODE_RUNNING);

	always_comb begin
		ramp_speed = cur.speed;
		tick_mode  = cur.mode;
		unique case (cur.mode)
			mcsr_pkg::MODE_STARTING: begin
				if (cur.speed < goal_eff) begin
					ramp_speed = ramp_up;
					if (up_sum >= {1'b0, goal_eff}) begin
						tick_mode = mcsr_pkg::MODE_RUNNING;
					end
				end
			end
			mcsr_pkg::MODE_RUNNING: begin
				if (cur.speed < goal_eff) begin
					ramp_speed = ramp_up;
				end else if (cur.speed > goal_eff) begin
					ramp_speed = ramp_dn_goal;
				end
			end
			mcsr_pkg::MODE_STOPPING: begin
				if (cur.speed != '0) begin
					ramp_speed = ramp_dn_zero;
					if (ramp_dn_zero == '0) begin
						tick_mode = mcsr_pkg::MODE_STOPPED;
					end
				end
			end
			default: begin
			end
		endcase

		tick_speed = ramp_speed;
		if (cfg.stall_fault && goal_eff >= cfg.stall_threshold) begin
			tick_speed = mcsr_pkg::SpeedW'(div20_prod[2*mcsr_pkg::SpeedW-1:mcsr_pkg::Div20Shift]);
		end

		run_sum = {1'b0, cur.runtime} + (mcsr_pkg::RunW + 1)'(secs);
	end

	always_comb begin
		nxt    = cur;
		status = mcsr_pkg::STATUS_OK;
		unique case (op)
			mcsr_pkg::OP_START: begin
				if (cur.mode != mcsr_pkg::MODE_STOPPED) begin
					status = mcsr_pkg::STATUS_REJECTED;
				end else begin
					nxt.mode = mcsr_pkg::MODE_STARTING;
				end
			end
			mcsr_pkg::OP_STOP: begin
				if (!active) begin
					status = mcsr_pkg::STATUS_REJECTED;
				end else begin
					nxt.mode = mcsr_pkg::MODE_STOPPING;
					nxt.goal = '0;
				end
			end
			mcsr_pkg::OP_SET_TARGET: begin
				if (!active) begin
					status = mcsr_pkg::STATUS_REJECTED;
				end else if (target_speed > mcsr_pkg::ReqW'(cfg.max_speed)) begin
					status = mcsr_pkg::STATUS_RANGE;
				end else begin
					nxt.goal = target_speed[mcsr_pkg::SpeedW-1:0];
				end
			end
			mcsr_pkg::OP_ESTOP: begin
				nxt.mode  = mcsr_pkg::MODE_ESTOP;
				nxt.goal  = '0;
				nxt.speed = '0;
			end
			mcsr_pkg::OP_CLEAR_ALARM, mcsr_pkg::OP_QUERY: begin
			end
			mcsr_pkg::OP_TICK: begin
				nxt.mode  = tick_mode;
				nxt.speed = tick_speed;
				nxt.goal  = goal_eff;
				if (tick_mode == mcsr_pkg::MODE_RUNNING) begin
					nxt.runtime = run_sum[mcsr_pkg::RunW] ? '1 : run_sum[mcsr_pkg::RunW-1:0];
				end
			end
			default: begin
				status = mcsr_pkg::STATUS_REJECTED;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/motor_command_speed_ramp.sv */
// ----------------------------------------------------------------------------
// Motor command and speed-ramp controller
// Runs the motor state machine on command and tick items and reports status,
// state, speed, target and accumulated run seconds for each item.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  cmd      in   valid / ready    operation, target_speed, elapsed_ms
//  rsp      out  valid / ready    status, motor_state, speed_now, speed_goal,
//                                 run_seconds
//  cfg      in   cfg_we           cfg_index, cfg_wdata
//
// An item is registered in the input register on acceptance and its result in the
// result register when it advances; one item can be accepted every cycle while the
// result is not stalled.
// The state registers double as the result payload and update only when the
// result register is free, which is what paces back-to-back items.
// A stalled result holds the input register; cmd.ready falls only then.
// Reset is asynchronous.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_command_speed_ramp_assert.svh"

module motor_command_speed_ramp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mcsr_cmd_if.sink                           cmd,
	mcsr_rsp_if.source                         rsp,
	input  wire logic                          cfg_we,
	input  wire logic [mcsr_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [mcsr_pkg::SpeedW-1:0]   cfg_wdata
);

	mcsr_pkg::cfg_t    cfg;
	mcsr_pkg::state_t  state_q;
	mcsr_pkg::state_t  state_nxt;
	mcsr_pkg::status_t status_nxt;
	mcsr_pkg::status_t status_q;

	logic                      valid_s1;
	logic [2:0]                op_s1;
	logic [mcsr_pkg::ReqW-1:0] tgt_s1;
	logic [mcsr_pkg::ReqW-1:0] ms_s1;
	logic                      rsp_valid_q;
	logic                      advance;
	logic                      take;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign take      = cmd.valid && cmd.ready;

	mcsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mcsr_step u_step (
		.cfg          (cfg),
		.cur          (state_q),
		.op           (mcsr_pkg::op_t'(op_s1)),
		.target_speed (tgt_s1),
		.elapsed_ms   (ms_s1),
		.nxt          (state_nxt),
		.status       (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= cmd.operation;
			tgt_s1 <= cmd.target_speed;
			ms_s1  <= cmd.elapsed_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q     <= 1'b0;
			status_q        <= mcsr_pkg::STATUS_OK;
			state_q.mode    <= mcsr_pkg::MODE_STOPPED;
			state_q.speed   <= '0;
			state_q.goal    <= '0;
			state_q.runtime <= '0;
		end else begin
			if (advance) begin
				rsp_valid_q <= 1'b1;
				status_q    <= status_nxt;
				state_q     <= state_nxt;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.motor_state = state_q.mode;
	assign rsp.speed_now   = state_q.speed;
	assign rsp.speed_goal  = state_q.goal;
	assign rsp.run_seconds = state_q.runtime;

	`MCSR_ASSERT_NEXT(a_estop_latched, clk, arst_n, state_q.mode == mcsr_pkg::MODE_ESTOP, state_q.mode == mcsr_pkg::MODE_ESTOP, "emergency stop state was left")
	`MCSR_ASSERT_SAME(a_stall_blocks, clk, arst_n, valid_s1 && rsp_valid_q && !rsp.ready, !cmd.ready, "item accepted while result stalled")
	`MCSR_ASSERT_NEXT(a_result_follows, clk, arst_n, advance, rsp_valid_q, "advanced item produced no result")
	`MCSR_ASSERT_NEXT(a_runtime_monotonic, clk, arst_n, 1'b1, state_q.runtime >= $past(state_q.runtime), "run time decreased")

endmodule

`default_nettype wire
